// ===== rtl/sha1md_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types, constants and round functions of the SHA-1 message digest.
// ----------------------------------------------------------------------------
package sha1md_pkg;

    localparam int WordW     = 32;
    localparam int SchedW    = 4;                 // schedule memory address bits
    localparam int RndW      = 7;                 // round counter bits
    localparam int LastRound = 79;
    localparam int NumWords  = 5;

    typedef logic [WordW-1:0] t_word;

    localparam t_word H_INIT [NumWords] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam t_word K_R0 = 32'h5A827999;
    localparam t_word K_R1 = 32'h6ED9EBA1;
    localparam t_word K_R2 = 32'h8F1BBCDC;
    localparam t_word K_R3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef struct packed {
        logic [7:0] message_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_msg_beat;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_dig_beat;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMP,
        S_PAD,
        S_OUT
    } t_state;

    // word load from the byte path into the schedule memory
    typedef struct packed {
        logic              en;
        logic [SchedW-1:0] addr;
        t_word             data;
    } t_wr_req;

    // schedule word for the round being executed
    typedef struct packed {
        logic            v;
        logic [RndW-1:0] rnd;
        t_word           w;
    } t_sched_out;

    function automatic t_word round_f(input logic [RndW-1:0] t,
                                      input t_word b, input t_word c, input t_word d);
        t_word f;
        begin
            if (t < RndW'(20)) begin
                f = (b & c) | (~b & d);
            end else if (t < RndW'(40)) begin
                f = b ^ c ^ d;
            end else if (t < RndW'(60)) begin
                f = (b & c) | (b & d) | (c & d);
            end else begin
                f = b ^ c ^ d;
            end
            return f;
        end
    endfunction

    function automatic t_word round_k(input logic [RndW-1:0] t);
        t_word k;
        begin
            if (t < RndW'(20)) begin
                k = K_R0;
            end else if (t < RndW'(40)) begin
                k = K_R1;
            end else if (t < RndW'(60)) begin
                k = K_R2;
            end else begin
                k = K_R3;
            end
            return k;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sha1md_stream_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha1md_stream_if
// Valid/ready channel carrying one payload beat of type T.
// ----------------------------------------------------------------------------
interface sha1md_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/sha1md_sched.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha1md_sched
// Message schedule memory: 16 words, held as two copies with two read ports
// each. Loads block words from the byte path, then serves W[t] per round,
// expanding and writing back W[t] into its circular slot.
// ----------------------------------------------------------------------------
module sha1md_sched (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  sha1md_pkg::t_wr_req                  i_load,
    input  logic                                 i_issue,
    input  logic [sha1md_pkg::RndW-1:0]          i_issue_rnd,
    output sha1md_pkg::t_sched_out               o_sched
);

    localparam int Depth = 2 ** sha1md_pkg::SchedW;

    sha1md_pkg::t_word r_mem_a [Depth];
    sha1md_pkg::t_word r_mem_b [Depth];
    sha1md_pkg::t_word r_q     [4];

    logic                          r_rd_v;
    logic [sha1md_pkg::RndW-1:0]   r_rd_rnd;

    logic [sha1md_pkg::SchedW-1:0] slot;
    logic [sha1md_pkg::SchedW-1:0] ra_m3;
    logic [sha1md_pkg::SchedW-1:0] ra_m8;
    logic [sha1md_pkg::SchedW-1:0] ra_m14;
    sha1md_pkg::t_word             mix;
    sha1md_pkg::t_word             w;
    logic                          wr_en;
    logic [sha1md_pkg::SchedW-1:0] wr_addr;
    sha1md_pkg::t_word             wr_data;

    assign slot   = i_issue_rnd[sha1md_pkg::SchedW-1:0];
    assign ra_m3  = slot - sha1md_pkg::SchedW'(3);
    assign ra_m8  = slot - sha1md_pkg::SchedW'(8);
    assign ra_m14 = slot - sha1md_pkg::SchedW'(14);

    // slot t also holds W[t-16] once t passes 15
    assign mix = r_q[0] ^ r_q[1] ^ r_q[2] ^ r_q[3];
    assign w   = (r_rd_rnd < sha1md_pkg::RndW'(16)) ? r_q[3]
               : {mix[sha1md_pkg::WordW-2:0], mix[sha1md_pkg::WordW-1]};

    assign wr_en   = r_rd_v | i_load.en;
    assign wr_addr = r_rd_v ? r_rd_rnd[sha1md_pkg::SchedW-1:0] : i_load.addr;
    assign wr_data = r_rd_v ? w : i_load.data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_a[wr_addr] <= wr_data;
            r_mem_b[wr_addr] <= wr_data;
        end
        r_q[0] <= r_mem_a[ra_m3];
        r_q[1] <= r_mem_a[ra_m8];
        r_q[2] <= r_mem_b[ra_m14];
        r_q[3] <= r_mem_b[slot];
        r_rd_rnd <= i_issue_rnd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
        end else begin
            r_rd_v <= i_issue;
        end
    end

    assign o_sched.v   = r_rd_v;
    assign o_sched.rnd = r_rd_rnd;
    assign o_sched.w   = w;

    a_no_wr_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_rd_v && i_load.en))
        else $error("schedule write-back collides with block load");

    a_issue_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_issue |=> (r_rd_v && r_rd_rnd == $past(i_issue_rnd)))
        else $error("issued round not presented one cycle later");

    a_rnd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_v |-> (r_rd_rnd <= sha1md_pkg::RndW'(sha1md_pkg::LastRound)))
        else $error("round index beyond last round");

endmodule
`default_nettype wire

// ===== rtl/sha1_message_digest.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_message_digest
// Streaming SHA-1: absorbs at most one byte per beat, pads at end of message and
// returns the five digest words.
// ----------------------------------------------------------------------------
// A full block runs one round per cycle through the shared round datapath,
// fed by the schedule memory's registered read, plus the add.
// End of message: padding at 1 byte per cycle through the length field
// (paused while a filled padding block compresses), one or two compressions,
// then 5 output beats. Ready is low from end to last beat.
// Reset (synchronous, active low) loads the initial chaining words and clears
// the byte count; the schedule memory is not cleared.
module sha1_message_digest (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    sha1md_stream_if.sink           i_msg,
    sha1md_stream_if.source         o_dig
);

    sha1md_pkg::t_state             r_state, n_state;
    logic [63:0]                    r_cnt, n_cnt;
    logic [23:0]                    r_acc, n_acc;
    sha1md_pkg::t_word              r_h [sha1md_pkg::NumWords];
    sha1md_pkg::t_word              n_h [sha1md_pkg::NumWords];
    sha1md_pkg::t_word              r_a, r_b, r_c, r_d, r_e;
    sha1md_pkg::t_word              n_a, n_b, n_c, n_d, n_e;
    logic                           r_issuing, n_issuing;
    logic [sha1md_pkg::RndW-1:0]    r_issue_rnd, n_issue_rnd;
    logic                           r_fin, n_fin;
    logic [63:0]                    r_bits, n_bits;
    logic                           r_pad_ph, n_pad_ph;
    logic                           r_pad_done, n_pad_done;
    logic                           r_padding, n_padding;
    logic                           r_len_blk, n_len_blk;
    logic                           r_end_pend, n_end_pend;
    logic [2:0]                     r_widx, n_widx;

    sha1md_pkg::t_msg_beat          msg;
    sha1md_pkg::t_dig_beat          dig;
    sha1md_pkg::t_wr_req            load;
    sha1md_pkg::t_sched_out         sched;
    logic                           msg_acc;
    logic                           dig_acc;
    logic                           put_en;
    logic [7:0]                     put_val;
    logic [5:0]                     pos;
    logic [63:0]                    cnt_plus;
    logic [63:0]                    cnt_end;
    logic                           len_here;
    sha1md_pkg::t_word              tmp;

    assign msg      = i_msg.data;
    assign msg_acc  = i_msg.valid & i_msg.ready;
    assign dig_acc  = o_dig.valid & o_dig.ready;
    assign pos      = r_cnt[5:0];
    assign cnt_plus = r_cnt + 64'd1;
    assign cnt_end  = msg.has_byte ? cnt_plus : r_cnt;

    // length field lands in this block
    assign len_here = r_pad_ph ? r_len_blk : (pos < 6'd56);

    assign tmp = {r_a[26:0], r_a[31:27]}
               + sha1md_pkg::round_f(sched.rnd, r_b, r_c, r_d)
               + r_e + sha1md_pkg::round_k(sched.rnd) + sched.w;

    sha1md_sched u_sched (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_issue     (r_issuing),
        .i_issue_rnd (r_issue_rnd),
        .o_sched     (sched)
    );

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_h         = r_h;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_d         = r_d;
        n_e         = r_e;
        n_issuing   = r_issuing;
        n_issue_rnd = r_issue_rnd;
        n_fin       = 1'b0;
        n_bits      = r_bits;
        n_pad_ph    = r_pad_ph;
        n_pad_done  = r_pad_done;
        n_padding   = r_padding;
        n_len_blk   = r_len_blk;
        n_end_pend  = r_end_pend;
        n_widx      = r_widx;
        put_en      = 1'b0;
        put_val     = 8'h00;

        unique case (r_state)
            sha1md_pkg::S_IDLE: begin
                if (msg_acc) begin
                    put_en  = msg.has_byte;
                    put_val = msg.message_byte;
                    if (msg.has_byte && pos == 6'd63) begin
                        n_state    = sha1md_pkg::S_COMP;
                        n_end_pend = msg.end_of_message;
                    end else if (msg.end_of_message) begin
                        n_state   = sha1md_pkg::S_PAD;
                        n_padding = 1'b1;
                        n_pad_ph  = 1'b0;
                        n_bits    = {cnt_end[60:0], 3'b000};
                    end
                end
            end
            sha1md_pkg::S_PAD: begin
                put_en    = 1'b1;
                n_len_blk = len_here;
                if (!r_pad_ph) begin
                    put_val  = sha1md_pkg::PAD_BYTE;
                    n_pad_ph = 1'b1;
                end else if (len_here && pos >= 6'd56) begin
                    put_val = r_bits[63:56];
                    n_bits  = {r_bits[55:0], 8'h00};
                end
                if (pos == 6'd63) begin
                    n_state = sha1md_pkg::S_COMP;
                    if (len_here) begin
                        n_pad_done = 1'b1;
                    end else begin
                        n_len_blk = 1'b1;
                    end
                end
            end
            sha1md_pkg::S_COMP: begin
                if (r_fin) begin
                    n_h[0] = r_h[0] + r_a;
                    n_h[1] = r_h[1] + r_b;
                    n_h[2] = r_h[2] + r_c;
                    n_h[3] = r_h[3] + r_d;
                    n_h[4] = r_h[4] + r_e;
                    priority if (r_pad_done) begin
                        n_state = sha1md_pkg::S_OUT;
                    end else if (r_padding) begin
                        n_state = sha1md_pkg::S_PAD;
                    end else if (r_end_pend) begin
                        n_state    = sha1md_pkg::S_PAD;
                        n_padding  = 1'b1;
                        n_pad_ph   = 1'b0;
                        n_bits     = {r_cnt[60:0], 3'b000};
                        n_end_pend = 1'b0;
                    end else begin
                        n_state = sha1md_pkg::S_IDLE;
                    end
                end
            end
            sha1md_pkg::S_OUT: begin
                if (dig_acc) begin
                    n_widx = r_widx + 3'd1;
                    if (r_widx == 3'(sha1md_pkg::NumWords - 1)) begin
                        n_state    = sha1md_pkg::S_IDLE;
                        n_widx     = 3'd0;
                        n_h        = sha1md_pkg::H_INIT;
                        n_cnt      = 64'd0;
                        n_pad_done = 1'b0;
                        n_padding  = 1'b0;
                        n_len_blk  = 1'b0;
                        n_end_pend = 1'b0;
                    end
                end
            end
        endcase

        if (put_en) begin
            n_cnt = cnt_plus;
            n_acc = {r_acc[15:0], put_val};
            if (pos == 6'd63) begin
                n_issuing   = 1'b1;
                n_issue_rnd = '0;
                n_a         = r_h[0];
                n_b         = r_h[1];
                n_c         = r_h[2];
                n_d         = r_h[3];
                n_e         = r_h[4];
            end
        end

        if (r_issuing) begin
            n_issue_rnd = r_issue_rnd + sha1md_pkg::RndW'(1);
            if (r_issue_rnd == sha1md_pkg::RndW'(sha1md_pkg::LastRound)) begin
                n_issuing = 1'b0;
            end
        end

        if (sched.v) begin
            n_e   = r_d;
            n_d   = r_c;
            n_c   = {r_b[1:0], r_b[31:2]};
            n_b   = r_a;
            n_a   = tmp;
            n_fin = (sched.rnd == sha1md_pkg::RndW'(sha1md_pkg::LastRound));
        end
    end

    always_comb begin
        load.en   = put_en && (pos[1:0] == 2'd3);
        load.addr = pos[5:2];
        load.data = {r_acc, put_val};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sha1md_pkg::S_IDLE;
            r_cnt       <= 64'd0;
            r_h         <= sha1md_pkg::H_INIT;
            r_issuing   <= 1'b0;
            r_issue_rnd <= '0;
            r_fin       <= 1'b0;
            r_pad_ph    <= 1'b0;
            r_pad_done  <= 1'b0;
            r_padding   <= 1'b0;
            r_len_blk   <= 1'b0;
            r_end_pend  <= 1'b0;
            r_widx      <= 3'd0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_h         <= n_h;
            r_issuing   <= n_issuing;
            r_issue_rnd <= n_issue_rnd;
            r_fin       <= n_fin;
            r_pad_ph    <= n_pad_ph;
            r_pad_done  <= n_pad_done;
            r_padding   <= n_padding;
            r_len_blk   <= n_len_blk;
            r_end_pend  <= n_end_pend;
            r_widx      <= n_widx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_a    <= n_a;
        r_b    <= n_b;
        r_c    <= n_c;
        r_d    <= n_d;
        r_e    <= n_e;
        r_bits <= n_bits;
    end

    always_comb begin
        dig.digest_word = r_h[r_widx];
        dig.word_index  = r_widx;
        dig.last_word   = (r_widx == 3'(sha1md_pkg::NumWords - 1));
    end

    assign i_msg.ready = (r_state == sha1md_pkg::S_IDLE);
    assign o_dig.valid = (r_state == sha1md_pkg::S_OUT);
    assign o_dig.data  = dig;

    a_no_accept_in_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_msg.ready |-> !(sched.v || r_issuing))
        else $error("input taken while compression is running");

    a_full_block_compresses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (msg_acc && msg.has_byte && pos == 6'd63) |=>
            (r_state == sha1md_pkg::S_COMP && r_issuing))
        else $error("full block did not start compression");

    a_restart_after_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dig_acc && dig.last_word) |=>
            (r_cnt == 64'd0 && r_h[0] == sha1md_pkg::H_INIT[0] &&
             r_state == sha1md_pkg::S_IDLE))
        else $error("state not reinitialized after last digest beat");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sha1_message_digest. Message beats go in on one
// valid/ready channel and digest words come out on another. A short table of
// directed messages runs first, then random messages of varied length and
// content. Both sides idle at random. Every digest word is checked against a
// bit-accurate SHA-1 model kept here, or against a known digest.
// ----------------------------------------------------------------------------
module tb;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 5;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT_WORD = 15;
    localparam int IDLE_PCT     = 23;
    localparam int RAND_ITEMS   = 100;
    localparam int CALM_FROM    = 40;
    localparam int CALM_TO      = 75;

    localparam int NO_REF    = -1;
    localparam int REF_EMPTY = 0;
    localparam int REF_ABC   = 1;

    localparam sha1md_pkg::t_word KNOWN_DIGEST [2][sha1md_pkg::NumWords] = '{
        '{32'hDA39A3EE, 32'h5E6B4B0D, 32'h3255BFEF, 32'h95601890, 32'hAFD80709},
        '{32'hA9993E36, 32'h4706816A, 32'hBA3E2571, 32'h7850C26C, 32'h9CD0D89D}
    };

    localparam int LONG_LENS [8] = '{55, 56, 57, 60, 62, 63, 64, 65};

    typedef struct {
        logic [7:0] msg_byte;
        logic       has;
        logic       eom;
        int         known;
    } t_row;

    t_row plan [19] = '{
        '{8'h00, 1'b0, 1'b1, REF_EMPTY},
        '{8'h5A, 1'b0, 1'b0, NO_REF},
        '{8'hA5, 1'b0, 1'b1, REF_EMPTY},
        '{8'h61, 1'b1, 1'b0, NO_REF},
        '{8'h62, 1'b1, 1'b0, NO_REF},
        '{8'h63, 1'b1, 1'b1, REF_ABC},
        '{8'h61, 1'b1, 1'b0, NO_REF},
        '{8'h62, 1'b1, 1'b0, NO_REF},
        '{8'h63, 1'b1, 1'b0, NO_REF},
        '{8'hC3, 1'b0, 1'b0, NO_REF},
        '{8'hFF, 1'b0, 1'b1, REF_ABC},
        '{8'h00, 1'b1, 1'b1, NO_REF},
        '{8'hFF, 1'b1, 1'b1, NO_REF},
        '{8'h80, 1'b1, 1'b1, NO_REF},
        '{8'hFF, 1'b1, 1'b0, NO_REF},
        '{8'h00, 1'b0, 1'b0, NO_REF},
        '{8'h00, 1'b1, 1'b0, NO_REF},
        '{8'h55, 1'b1, 1'b0, NO_REF},
        '{8'hAA, 1'b0, 1'b1, NO_REF}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #CLK_HALF i_clk = ~i_clk;

    sha1md_stream_if #(.T(sha1md_pkg::t_msg_beat)) msg_if ();
    sha1md_stream_if #(.T(sha1md_pkg::t_dig_beat)) dig_if ();

    sha1_message_digest dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_msg   (msg_if),
        .o_dig   (dig_if)
    );

    // hash state of the bench's own model, kept apart from the block
    sha1md_pkg::t_word chain [sha1md_pkg::NumWords];
    logic [7:0]        blk [64];
    logic [63:0]       nbytes;

    sha1md_pkg::t_dig_beat digest_due [$];
    int                    errors     = 0;
    int                    words_seen = 0;
    int                    cycles     = 0;
    logic                  calm       = 1'b0;

    function automatic sha1md_pkg::t_word rol(input sha1md_pkg::t_word v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic void sha_init();
        chain[0] = 32'h67452301;
        chain[1] = 32'hEFCDAB89;
        chain[2] = 32'h98BADCFE;
        chain[3] = 32'h10325476;
        chain[4] = 32'hC3D2E1F0;
        nbytes   = '0;
    endfunction

    function automatic void sha_compress();
        sha1md_pkg::t_word w [80];
        sha1md_pkg::t_word a, b, c, d, e, f, k, tmp;
        for (int t = 0; t < 16; t++) begin
            w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        end
        for (int t = 16; t < 80; t++) begin
            w[t] = rol(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
        end
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int t = 0; t < 80; t++) begin
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            tmp = rol(a, 5) + f + e + k + w[t];
            e   = d;
            d   = c;
            c   = rol(b, 30);
            b   = a;
            a   = tmp;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endfunction

    function automatic void sha_put(input logic [7:0] v);
        logic [5:0] pos;
        pos      = nbytes[5:0];
        blk[pos] = v;
        nbytes   = nbytes + 64'd1;
        if (pos == 6'd63) begin
            sha_compress();
        end
    endfunction

    // absorb one accepted beat; at end of message queue the five digest words
    function automatic void sha_absorb(input sha1md_pkg::t_msg_beat beat, input int known);
        logic [63:0]           bits;
        sha1md_pkg::t_dig_beat word;
        if (beat.has_byte) begin
            sha_put(beat.message_byte);
        end
        if (!beat.end_of_message) begin
            return;
        end
        bits = nbytes << 3;
        sha_put(8'h80);
        while (nbytes[5:0] != 6'd56) begin
            sha_put(8'h00);
        end
        for (int i = 7; i >= 0; i--) begin
            sha_put(bits[8*i +: 8]);
        end
        for (int i = 0; i < sha1md_pkg::NumWords; i++) begin
            word.digest_word = (known == NO_REF) ? chain[i] : KNOWN_DIGEST[known][i];
            word.word_index  = 3'(i);
            word.last_word   = (i == sha1md_pkg::NumWords - 1);
            digest_due.push_back(word);
        end
        sha_init();
    endfunction

    task automatic check_digest_word(input sha1md_pkg::t_dig_beat got);
        sha1md_pkg::t_dig_beat want;
        if (digest_due.size() == 0) begin
            $error("digest_word: none expected, got %h", got.digest_word);
            errors++;
            return;
        end
        want = digest_due.pop_front();
        if (got.digest_word !== want.digest_word) begin
            $error("digest_word: expected %h, got %h", want.digest_word, got.digest_word);
            errors++;
        end
        if (got.word_index !== want.word_index) begin
            $error("word_index: expected %0d, got %0d", want.word_index, got.word_index);
            errors++;
        end
        if (got.last_word !== want.last_word) begin
            $error("last_word: expected %b, got %b", want.last_word, got.last_word);
            errors++;
        end
    endtask

    // called at a rising edge; returns at the edge the beat is taken
    task automatic send_beat(input logic [7:0] b, input logic has, input logic eom,
                             input int known);
        sha1md_pkg::t_msg_beat beat;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            msg_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        beat.message_byte   = b;
        beat.has_byte       = has;
        beat.end_of_message = eom;
        msg_if.data  <= beat;
        msg_if.valid <= 1'b1;
        do @(posedge i_clk); while (!msg_if.ready);
        sha_absorb(beat, known);
    endtask

    initial begin : digest_sink
        int   hold_left;
        logic held;
        hold_left    = 0;
        held         = 1'b0;
        dig_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (dig_if.valid && dig_if.ready) begin
                    check_digest_word(dig_if.data);
                    words_seen++;
                    // long hold-off so the sender backs up behind a digest
                    if (!held && words_seen == HOLD_AT_WORD) begin
                        held      = 1'b1;
                        hold_left = HOLD_CYCLES;
                    end
                end
                if (hold_left > 0) begin
                    hold_left--;
                    dig_if.ready <= 1'b0;
                end else begin
                    dig_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : msg_source
        int   items;
        int   msgs;
        int   len;
        int   pick;
        logic close_with_byte;
        items        = 0;
        msgs         = 0;
        msg_if.valid = 1'b0;
        msg_if.data  = '0;
        sha_init();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[r]) begin
            send_beat(plan[r].msg_byte, plan[r].has, plan[r].eom, plan[r].known);
        end

        // sender stands still until all digests are back
        msg_if.valid <= 1'b0;
        while (digest_due.size() != 0) @(posedge i_clk);

        while (items < RAND_ITEMS) begin
            pick = $urandom_range(99);
            if (msgs == 0 || pick >= 85) begin
                len = LONG_LENS[$urandom_range(7)];
            end else if (pick < 60) begin
                len = $urandom_range(12);
            end else begin
                len = $urandom_range(54, 13);
            end
            if (len > RAND_ITEMS - items) begin
                len = RAND_ITEMS - items;
            end
            close_with_byte = (len > 0) && ($urandom_range(1) == 1);
            for (int i = 0; i < len; i++) begin
                calm <= (items >= CALM_FROM && items < CALM_TO);
                if ($urandom_range(9) == 0) begin
                    send_beat(8'($urandom_range(255)), 1'b0, 1'b0, NO_REF);
                    items++;
                end
                send_beat(8'($urandom_range(255)), 1'b1,
                          close_with_byte && (i == len - 1), NO_REF);
                items++;
            end
            if (!close_with_byte) begin
                calm <= (items >= CALM_FROM && items < CALM_TO);
                send_beat(8'($urandom_range(255)), 1'b0, 1'b1, NO_REF);
                items++;
            end
            msgs++;
        end

        msg_if.valid <= 1'b0;
        calm         <= 1'b0;
        while (digest_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && digest_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
